[src/assert_macros.svh]
// assertion macros of the heading error block, included by the sequencing controller
// each macro assumes a clock named clk and a synchronous reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define WPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define WPH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/wph_pkg.sv]
// shared types and constants of the waypoint heading error block
// no dependencies; used by the controller, the datapath and the top level
package wph_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DEST_LAT  = 2'd0;
  localparam logic [1:0] REG_DEST_LON  = 2'd1;
  localparam logic [1:0] REG_DEADBAND  = 2'd2;

  // reset values of the configuration registers
  localparam logic signed [30:0] DEST_LAT_RESET = 31'sd100000034;
  localparam logic signed [31:0] DEST_LON_RESET = 32'sd100000010;
  localparam logic [14:0]        DEADBAND_RESET = 15'd400;

  // datapath widths
  localparam int XY_W   = 36;   // cordic x and y, holds gain growth of a 33 bit vector
  localparam int Z_W    = 34;   // angle accumulator, 2^32 per turn
  localparam int ZABS_W = 33;
  localparam int PROD_W = 49;

  // angle constants
  localparam logic signed [Z_W-1:0] ANG_QUARTER = 34'sd1073741824;
  localparam logic [15:0]           CDEG_TURN   = 16'd36000;
  localparam logic signed [17:0]    CDEG_HALF   = 18'sd18000;
  localparam logic signed [17:0]    CDEG_FULL   = 18'sd36000;
  localparam logic [PROD_W-1:0]     ROUND_HALF  = 49'h0_0000_8000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;   // take the input fix
    logic       load;      // load the cordic with a difference vector
    logic       step;      // one vectoring iteration
    logic [4:0] idx;       // iteration index
    logic       conv1;     // angle magnitude times 36000
    logic       conv2;     // round and wrap to hundredths
    logic       err;       // heading error and dead band
    logic       sel_b;     // second pass: heading from the previous fix
    logic       out_load;  // move results into the output register
  } wph_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic axis;            // difference vector has zero latitude change
  } wph_status_t;

  // atan(2^-i) in angle units of 2^32 per turn
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/wph_ctrl.sv]
// sequencing controller: two cordic passes per fix, then the output register
// depends on wph_pkg and assert_macros.svh
`include "assert_macros.svh"

module wph_ctrl
  import wph_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  wph_status_t status,
  output wph_cmd_t    cmd
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ITER,
    S_CONV1,
    S_CONV2,
    S_ERR,
    S_DONE
  } state_t;

  state_t        state;
  logic          phase;
  logic [CW-1:0] cnt;
  logic          accept;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.load     = (state == S_LOAD);
    cmd.step     = (state == S_ITER) && !status.axis;
    cmd.idx      = 5'(cnt);
    cmd.conv1    = (state == S_CONV1);
    cmd.conv2    = (state == S_CONV2);
    cmd.err      = (state == S_ERR);
    cmd.sel_b    = phase;
    cmd.out_load = (state == S_DONE) && out_free;
  end

  // state, pass, iteration count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output valid: set on a result load, cleared when taken
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
            phase <= 1'b0;
          end
        end
        S_LOAD: begin
          state <= S_ITER;
          cnt   <= '0;
        end
        S_ITER: begin
          if (status.axis || cnt == LAST) begin
            state <= S_CONV1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CONV1: state <= S_CONV2;
        S_CONV2: state <= phase ? S_DONE : S_ERR;
        S_ERR: begin
          state <= S_LOAD;
          phase <= 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `WPH_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid || out_ready), "result overwritten")
  `WPH_ASSERT(a_load_valid, cmd.out_load |=> out_valid, "loaded result not valid")
  `WPH_ASSERT(a_start_pass, accept |=> (state == S_LOAD && !phase), "accept did not start first pass")
  `WPH_ASSERT(a_cnt_range, cnt <= LAST, "iteration count out of range")

endmodule

[src/wph_datapath.sv]
// datapath: config registers, fix and heading state, shared cordic atan2 unit,
// angle conversion, heading error and output register; depends on wph_pkg
module wph_datapath
  import wph_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [30:0] rover_lat,
  input  logic signed [31:0] rover_lon,
  input  wph_cmd_t           cmd,
  output wph_status_t        status,
  output logic signed [15:0] turn_error,
  output logic signed [15:0] bearing
);

  // configuration and state
  logic signed [30:0] dest_lat;
  logic signed [31:0] dest_lon;
  logic [14:0]        deadband;
  logic signed [30:0] prev_lat;
  logic signed [31:0] prev_lon;
  logic signed [15:0] heading;

  // working registers
  logic signed [30:0]       fix_lat;
  logic signed [31:0]       fix_lon;
  logic signed [XY_W-1:0]   cx;
  logic signed [XY_W-1:0]   cy;
  logic signed [Z_W-1:0]    cz;
  logic                     axis;
  logic                     axis_neg;
  logic                     zneg;
  logic [PROD_W-1:0]        prod;
  logic signed [15:0]       brg;
  logic signed [15:0]       err;

  // difference vector operands
  logic signed [30:0] ya, yb;
  logic signed [31:0] xa, xb;
  logic signed [31:0] dy, ndy;
  logic signed [32:0] dx, ndx;
  logic               dy_zero, dy_pos, dx_neg;

  // cordic step terms
  logic signed [XY_W-1:0] sx, sy;
  logic signed [Z_W-1:0]  tab;
  logic                   y_pos;

  // conversion terms
  logic [ZABS_W-1:0] zabs;
  logic [PROD_W-1:0] rsum;
  logic [16:0]       qmag;
  logic signed [17:0] q, qw;
  logic signed [15:0] ang;

  // error terms
  logic signed [16:0] e, ew, emag;

  assign status.axis = axis;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_lat <= DEST_LAT_RESET;
      dest_lon <= DEST_LON_RESET;
      deadband <= DEADBAND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEST_LAT: dest_lat <= cfg_data[30:0];
        REG_DEST_LON: dest_lon <= cfg_data;
        REG_DEADBAND: deadband <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // operand select and pre-rotation of vectors with negative x
  always_comb begin
    ya      = cmd.sel_b ? fix_lat : dest_lat;
    yb      = cmd.sel_b ? prev_lat : fix_lat;
    xa      = cmd.sel_b ? fix_lon : dest_lon;
    xb      = cmd.sel_b ? prev_lon : fix_lon;
    dy      = 32'(ya) - 32'(yb);
    ndy     = 32'(yb) - 32'(ya);
    dx      = 33'(xa) - 33'(xb);
    ndx     = 33'(xb) - 33'(xa);
    dy_zero = (dy == '0);
    dy_pos  = !dy[31] && !dy_zero;
    dx_neg  = dx[32];
  end

  // cordic step
  always_comb begin
    sx    = cx >>> cmd.idx;
    sy    = cy >>> cmd.idx;
    tab   = Z_W'(atan_entry(cmd.idx));
    y_pos = !cy[XY_W-1] && (cy != '0);
  end

  // angle conversion: round half away from zero, then wrap
  always_comb begin
    zabs = cz[Z_W-1] ? ZABS_W'(-cz) : ZABS_W'(cz);
    rsum = prod + ROUND_HALF;
    qmag = rsum[PROD_W-1:32];
    q    = zneg ? -18'(qmag) : 18'(qmag);
    if (q > CDEG_HALF) begin
      qw = q - CDEG_FULL;
    end else if (q <= -CDEG_HALF) begin
      qw = q + CDEG_FULL;
    end else begin
      qw = q;
    end
    if (axis) begin
      ang = axis_neg ? 16'(CDEG_HALF) : 16'sd0;
    end else begin
      ang = qw[15:0];
    end
  end

  // heading error with wrap and dead band
  always_comb begin
    e = 17'(brg) - 17'(heading);
    if (e > 17'(CDEG_HALF)) begin
      ew = e - 17'(CDEG_FULL);
    end else if (e <= -17'(CDEG_HALF)) begin
      ew = e + 17'(CDEG_FULL);
    end else begin
      ew = e;
    end
    emag = ew[16] ? -ew : ew;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lat <= '0;
      prev_lon <= '0;
      heading  <= '0;
    end else if (cmd.conv2 && cmd.sel_b) begin
      heading  <= ang;
      prev_lat <= fix_lat;
      prev_lon <= fix_lon;
    end
  end

  // working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fix_lat <= rover_lat;
      fix_lon <= rover_lon;
    end
    if (cmd.load) begin
      axis     <= dy_zero;
      axis_neg <= dx_neg;
      if (dx_neg && dy_pos) begin
        cx <= XY_W'(dy);
        cy <= XY_W'(ndx);
        cz <= ANG_QUARTER;
      end else if (dx_neg) begin
        cx <= XY_W'(ndy);
        cy <= XY_W'(dx);
        cz <= -ANG_QUARTER;
      end else begin
        cx <= XY_W'(dx);
        cy <= XY_W'(dy);
        cz <= '0;
      end
    end else if (cmd.step) begin
      if (y_pos) begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + tab;
      end else begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - tab;
      end
    end
    if (cmd.conv1) begin
      zneg <= cz[Z_W-1];
      prod <= PROD_W'(zabs) * PROD_W'(CDEG_TURN);
    end
    if (cmd.conv2 && !cmd.sel_b) begin
      brg <= ang;
    end
    if (cmd.err) begin
      err <= (emag <= 17'(deadband)) ? 16'sd0 : ew[15:0];
    end
    if (cmd.out_load) begin
      turn_error <= err;
      bearing    <= brg;
    end
  end

endmodule

[src/waypoint_heading_error_core.sv]
// Sequence per fix: capture, bearing pass (load, cordic iterations, conversion), heading
// error, heading pass, then output load once the output register is free; a pass whose
// difference vector has zero latitude change ends its iterations early. A new fix is
// taken only after that load: the single cordic unit runs both passes for each fix.
// Reset: synchronous; config registers return to their defaults, previous fix and
// heading clear to zero, no result pending.
module waypoint_heading_error_core
  import wph_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // rover_lat [30:0], rover_lon [62:31], bit 63 unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // turn_error [15:0], bearing [31:16]
);

  wph_cmd_t           cmd;
  wph_status_t        status;
  logic signed [15:0] turn_error;
  logic signed [15:0] bearing;

  // config writes always taken
  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {bearing, turn_error};

  // sequencing controller
  wph_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  wph_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rover_lat (s_axis_tdata[30:0]),
    .rover_lon (s_axis_tdata[62:31]),
    .cmd       (cmd),
    .status    (status),
    .turn_error(turn_error),
    .bearing   (bearing)
  );

endmodule
